// File: rtl/tfc_pkg.sv
// Types and constants shared by the TCP flow table counter.
`default_nettype none

package tfc_pkg;

   localparam logic OP_ACCOUNT = 1'b0;
   localparam logic OP_READ    = 1'b1;

   localparam logic [7:0] PROTO_TCP = 8'd6;

   localparam logic [2:0] ST_EXISTING   = 3'd0;
   localparam logic [2:0] ST_NEW        = 3'd1;
   localparam logic [2:0] ST_IGNORED    = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_READ_OK    = 3'd4;
   localparam logic [2:0] ST_READ_EMPTY = 3'd5;

   localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
   localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic        op;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] ip_length;
      logic [5:0]  read_index;
      logic        done;
      logic [2:0]  status;
      logic [5:0]  entry_index;
      logic [31:0] flow_src_addr;
      logic [31:0] flow_dst_addr;
      logic [15:0] flow_sport;
      logic [15:0] flow_dport;
      logic [31:0] packet_total;
      logic [47:0] byte_total;
   } tfc_tok_type;

endpackage

`default_nettype wire

// File: rtl/tfc_if.sv
// Request and response channel interfaces of the TCP flow table counter.
`default_nettype none

interface tfc_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  protocol;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] sport;
   logic [15:0] dport;
   logic [15:0] ip_length;
   logic [5:0]  read_index;

   modport source (
      output valid, operation, protocol, src_addr, dst_addr, sport, dport,
             ip_length, read_index,
      input  ready
   );
   modport sink (
      input  valid, operation, protocol, src_addr, dst_addr, sport, dport,
             ip_length, read_index,
      output ready
   );
endinterface

interface tfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  entry_index;
   logic [31:0] flow_src_addr;
   logic [31:0] flow_dst_addr;
   logic [15:0] flow_sport;
   logic [15:0] flow_dport;
   logic [31:0] packet_total;
   logic [47:0] byte_total;

   modport source (
      output valid, status, entry_index, flow_src_addr, flow_dst_addr, flow_sport,
             flow_dport, packet_total, byte_total,
      input  ready
   );
   modport sink (
      input  valid, status, entry_index, flow_src_addr, flow_dst_addr, flow_sport,
             flow_dport, packet_total, byte_total,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/tfc_cell.sv
// One flow table entry with its match, allocate, count and read logic, passing the transaction on.
`default_nettype none

module tfc_cell
   import tfc_pkg::*;
#(
   parameter int unsigned CELL_INDEX = 0
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  advance,
   input  wire tfc_tok_type up_tok,
   input  wire logic  up_valid,
   output tfc_tok_type dn_tok,
   output logic       dn_valid,
   output logic       entry_valid
);

   tfc_tok_type tok_ff, tok_in;
   logic        tok_valid_ff;
   logic        valid_ff, valid_in;
   logic [31:0] addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic [15:0] port_a_ff, port_a_in, port_b_ff, port_b_in;
   logic [31:0] packets_ff, packets_in;
   logic [47:0] bytes_ff, bytes_in;
   logic        fwd_match, rev_match;
   logic [48:0] byte_sum;

   always_comb begin
      fwd_match = addr_a_ff == up_tok.src_addr && port_a_ff == up_tok.sport &&
                  addr_b_ff == up_tok.dst_addr && port_b_ff == up_tok.dport;
      rev_match = addr_a_ff == up_tok.dst_addr && port_a_ff == up_tok.dport &&
                  addr_b_ff == up_tok.src_addr && port_b_ff == up_tok.sport;
      byte_sum  = {1'b0, bytes_ff} + 49'(up_tok.ip_length);

      tok_in     = up_tok;
      valid_in   = valid_ff;
      addr_a_in  = addr_a_ff;
      addr_b_in  = addr_b_ff;
      port_a_in  = port_a_ff;
      port_b_in  = port_b_ff;
      packets_in = packets_ff;
      bytes_in   = bytes_ff;

      if (up_valid && !up_tok.done) begin
         if (up_tok.op == OP_READ) begin
            if (valid_ff && 32'(up_tok.read_index) == 32'(CELL_INDEX)) begin
               tok_in.done   = 1'b1;
               tok_in.status = ST_READ_OK;
            end
         end else if (valid_ff) begin
            if (fwd_match || rev_match) begin
               packets_in         = (packets_ff == PKT_MAX) ? packets_ff : packets_ff + 32'd1;
               bytes_in           = byte_sum[48] ? BYTE_MAX : byte_sum[47:0];
               tok_in.done        = 1'b1;
               tok_in.status      = ST_EXISTING;
               tok_in.entry_index = 6'(CELL_INDEX);
            end
         end else begin
            valid_in           = 1'b1;
            addr_a_in          = up_tok.src_addr;
            addr_b_in          = up_tok.dst_addr;
            port_a_in          = up_tok.sport;
            port_b_in          = up_tok.dport;
            packets_in         = 32'd1;
            bytes_in           = 48'(up_tok.ip_length);
            tok_in.done        = 1'b1;
            tok_in.status      = ST_NEW;
            tok_in.entry_index = 6'(CELL_INDEX);
         end

         if (tok_in.done) begin
            tok_in.flow_src_addr = addr_a_in;
            tok_in.flow_dst_addr = addr_b_in;
            tok_in.flow_sport    = port_a_in;
            tok_in.flow_dport    = port_b_in;
            tok_in.packet_total  = packets_in;
            tok_in.byte_total    = bytes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (advance) begin
         tok_valid_ff <= up_valid;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_ff     <= tok_in;
         addr_a_ff  <= addr_a_in;
         addr_b_ff  <= addr_b_in;
         port_a_ff  <= port_a_in;
         port_b_ff  <= port_b_in;
         packets_ff <= packets_in;
         bytes_ff   <= bytes_in;
      end
   end

   assign dn_tok      = tok_ff;
   assign dn_valid    = tok_valid_ff;
   assign entry_valid = valid_ff;

endmodule

`default_nettype wire

// File: rtl/tcp_flow_table_counter.sv
// Top level of the TCP flow table counter: request decode, cell chain and response register.
//
// Channel  Modport  Direction  Contents
// req_bus  sink     in         operation, protocol, addresses, ports, ip_length, read_index
// rsp_bus  source   out        status, entry_index, stored tuple, packet and byte totals
//
// Each transaction walks the chain of FLOW_ENTRIES cells, one cell per cycle while the chain
// is not frozen, and its response is then captured in the output register.
// The chain takes a new transaction in every cycle in which it is not frozen; throughput is one per cycle.
// The whole chain freezes only while a response waits unaccepted in the output register
// and the next one has reached the end of the chain.
// Reset clears all valid bits and the fill state.
`default_nettype none

module tcp_flow_table_counter
   import tfc_pkg::*;
#(
   parameter int unsigned FLOW_ENTRIES = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tfc_req_if.sink    req_bus,
   tfc_rsp_if.source  rsp_bus
);

   tfc_tok_type             head_tok;
   tfc_tok_type             chain_tok   [FLOW_ENTRIES+1];
   logic [FLOW_ENTRIES:0]   chain_valid;
   logic [FLOW_ENTRIES-1:0] valid_vec;
   logic                    advance;
   logic                    last_valid;
   logic                    rsp_valid_ff, rsp_valid_in;
   tfc_tok_type             rsp_tok_ff;

   always_comb begin
      head_tok            = '0;
      head_tok.op         = req_bus.operation;
      head_tok.src_addr   = req_bus.src_addr;
      head_tok.dst_addr   = req_bus.dst_addr;
      head_tok.sport      = req_bus.sport;
      head_tok.dport      = req_bus.dport;
      head_tok.ip_length  = req_bus.ip_length;
      head_tok.read_index = req_bus.read_index;
      if (req_bus.operation == OP_READ) begin
         head_tok.status      = ST_READ_EMPTY;
         head_tok.entry_index = req_bus.read_index;
      end else if (req_bus.protocol != PROTO_TCP) begin
         head_tok.status = ST_IGNORED;
         head_tok.done   = 1'b1;
      end else begin
         head_tok.status = ST_FULL;
      end
   end

   assign last_valid     = chain_valid[FLOW_ENTRIES];
   assign advance        = !rsp_valid_ff || rsp_bus.ready || !last_valid;
   assign req_bus.ready  = advance;
   assign chain_tok[0]   = head_tok;
   assign chain_valid[0] = req_bus.valid && advance;

   for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
      tfc_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .up_tok      (chain_tok[i]),
         .up_valid    (chain_valid[i]),
         .dn_tok      (chain_tok[i+1]),
         .dn_valid    (chain_valid[i+1]),
         .entry_valid (valid_vec[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && last_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_valid) begin
         rsp_tok_ff <= chain_tok[FLOW_ENTRIES];
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_tok_ff.status;
   assign rsp_bus.entry_index   = rsp_tok_ff.entry_index;
   assign rsp_bus.flow_src_addr = rsp_tok_ff.flow_src_addr;
   assign rsp_bus.flow_dst_addr = rsp_tok_ff.flow_dst_addr;
   assign rsp_bus.flow_sport    = rsp_tok_ff.flow_sport;
   assign rsp_bus.flow_dport    = rsp_tok_ff.flow_dport;
   assign rsp_bus.packet_total  = rsp_tok_ff.packet_total;
   assign rsp_bus.byte_total    = rsp_tok_ff.byte_total;

   // Entries are allocated in order, so the valid entries always form a prefix of the table.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & ~{valid_vec[FLOW_ENTRIES-2:0], 1'b1}) == '0)
      else $error("flow table valid bits are not a prefix");

   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      last_valid && !advance |=> last_valid && $stable(chain_tok[FLOW_ENTRIES]))
      else $error("chain moved while the response register was blocked");

   a_new_count: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == ST_NEW |-> rsp_bus.packet_total == 32'd1)
      else $error("new flow reported with a packet count other than one");

endmodule

`default_nettype wire
